// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and held off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/slc_pkg.sv =====
// ---------------------------------------------------------------------------
// slc_pkg
// Request and status codes, cell operation codes and the result record.
// ---------------------------------------------------------------------------
package slc_pkg;

    localparam int REQ_W   = 3;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = 6;
    localparam int DOUT_W  = 32;
    localparam int POS_W   = 6;
    localparam int CNT_W   = 7;
    localparam int FILL_W  = 7;
    localparam int STAT_W  = 2;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_PUSH  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FIND  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_COUNT = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd5;

    // Result status
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNDER = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVER  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

    // Cell operations
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op CELL_HOLD  = 2'd0;
    localparam t_cell_op CELL_PUSH  = 2'd1; // take the neighbour below (towards the head)
    localparam t_cell_op CELL_SHIFT = 2'd2; // take the neighbour above, ring wraps to the head

    typedef struct packed {
        logic [DOUT_W-1:0] data_out;
        logic              found;
        logic [POS_W-1:0]  position;
        logic [CNT_W-1:0]  match_count;
        logic [FILL_W-1:0] fill;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

// ===== src/slc_cell.sv =====
// ---------------------------------------------------------------------------
// slc_cell
// One storage cell of the stack ring: holds one entry, loads from a neighbour.
// ---------------------------------------------------------------------------
module slc_cell import slc_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [DATA_WIDTH-1:0] i_from_prev,
    input  logic [DATA_WIDTH-1:0] i_from_next,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        unique case (i_op)
            CELL_PUSH:  n_data = i_from_prev;
            CELL_SHIFT: n_data = i_from_next;
            default:    n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== src/slc_ctrl.sv =====
// ---------------------------------------------------------------------------
// slc_ctrl
// Request sequencer: occupancy, ring scan for read/find/count, result stages.
// ---------------------------------------------------------------------------
module slc_ctrl import slc_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [IDX_W-1:0]      i_index,
    input  logic [DATA_WIDTH-1:0] i_head,
    output t_cell_op              o_op,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_result               o_res
);

    localparam int OW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);
    localparam int CW = (OW > IDX_W + 1) ? OW : IDX_W + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                  r_state,  n_state;
    logic [SW-1:0]         r_step,   n_step;
    logic [OW-1:0]         r_occ,    n_occ;
    logic [REQ_W-1:0]      r_kind,   n_kind;
    logic [DATA_WIDTH-1:0] r_key,    n_key;
    logic [SW-1:0]         r_target, n_target;
    logic                  r_found,  n_found;
    logic [SW-1:0]         r_pos,    n_pos;
    logic [OW-1:0]         r_cnt,    n_cnt;
    logic [DATA_WIDTH-1:0] r_rdata,  n_rdata;
    logic                  r_pend_v, n_pend_v;
    t_result               r_pend,   n_pend;
    logic                  r_out_v,  n_out_v;
    t_result               r_out,    n_out;

    logic    w_move;
    logic    w_accept;
    logic    w_hit;
    logic    w_load;
    t_result w_res;
    logic [CW-1:0] w_idx_ext;
    logic [CW-1:0] w_occ_ext;

    // Pending result advances whenever the output stage is free or draining
    assign w_move    = r_pend_v && (!r_out_v || i_res_ready);
    assign o_ready   = (r_state == S_IDLE) && (!r_pend_v || w_move);
    assign w_accept  = i_valid && o_ready;
    assign w_idx_ext = CW'(i_index);
    assign w_occ_ext = CW'(r_occ);
    assign w_hit     = (i_head == r_key) && (OW'(r_step) < r_occ);

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_occ    = r_occ;
        n_kind   = r_kind;
        n_key    = r_key;
        n_target = r_target;
        n_found  = r_found;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_rdata  = r_rdata;
        o_op     = CELL_HOLD;
        w_load   = 1'b0;
        w_res    = '0;

        if (r_state == S_SCAN) begin
            o_op = CELL_SHIFT;
            if (r_kind == REQ_FIND && w_hit) begin
                // later steps see lower indices: keep the last hit
                n_found = 1'b1;
                n_pos   = SW'(r_occ - OW'(1) - OW'(r_step));
            end
            if (r_kind == REQ_COUNT && w_hit) begin
                n_cnt = r_cnt + OW'(1);
            end
            if (r_kind == REQ_READ && r_step == r_target) begin
                n_rdata = i_head;
            end
            if (r_step == SW'(DEPTH - 1)) begin
                n_state           = S_IDLE;
                w_load            = 1'b1;
                w_res.data_out    = DOUT_W'(n_rdata);
                w_res.found       = n_found;
                w_res.position    = POS_W'(n_pos);
                w_res.match_count = CNT_W'(n_cnt);
                w_res.fill        = FILL_W'(r_occ);
                w_res.status      = STAT_OK;
            end else begin
                n_step = r_step + SW'(1);
            end
        end else if (w_accept) begin
            w_load = 1'b1;
            unique case (i_req_type)
                REQ_PUSH: begin
                    if (r_occ == OW'(DEPTH)) begin
                        w_res.status = STAT_OVER;
                    end else begin
                        o_op  = CELL_PUSH;
                        n_occ = r_occ + OW'(1);
                    end
                end
                REQ_POP: begin
                    if (r_occ == '0) begin
                        w_res.status = STAT_UNDER;
                    end else begin
                        o_op           = CELL_SHIFT;
                        n_occ          = r_occ - OW'(1);
                        w_res.data_out = DOUT_W'(i_head);
                    end
                end
                REQ_READ, REQ_FIND, REQ_COUNT: begin
                    if (i_req_type == REQ_READ && w_idx_ext >= w_occ_ext) begin
                        w_res.status = STAT_RANGE;
                    end else begin
                        w_load   = 1'b0;
                        n_state  = S_SCAN;
                        n_step   = '0;
                        n_kind   = i_req_type;
                        n_key    = i_value;
                        n_target = SW'(w_occ_ext - CW'(1) - w_idx_ext);
                        n_found  = 1'b0;
                        n_pos    = '0;
                        n_cnt    = '0;
                        n_rdata  = '0;
                    end
                end
                REQ_CLEAR: begin
                    n_occ = '0;
                end
                default: begin
                end
            endcase
            w_res.fill = FILL_W'(n_occ);
        end
    end

    always_comb begin
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_out_v  = r_out_v;
        n_out    = r_out;
        if (w_move) begin
            n_out   = r_pend;
            n_out_v = 1'b1;
        end else if (r_out_v && i_res_ready) begin
            n_out_v = 1'b0;
        end
        if (w_load) begin
            n_pend   = w_res;
            n_pend_v = 1'b1;
        end else if (w_move) begin
            n_pend_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_occ    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_occ    <= n_occ;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_key    <= n_key;
        r_target <= n_target;
        r_found  <= n_found;
        r_pos    <= n_pos;
        r_cnt    <= n_cnt;
        r_rdata  <= n_rdata;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

endmodule

// ===== src/searchable_lifo_stack_top.sv =====
// ---------------------------------------------------------------------------
// searchable_lifo_stack_top
// Bounded LIFO stack with indexed read, find-first and match count.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_ready) carries req_type, value, index;
//   a transaction is taken on an edge where both are high. Result channel
//   (o_out_valid / i_out_ready) returns exactly one result per request.
//   Push, pop, clear, undefined kinds and out-of-range reads complete at once:
//   the result passes the pending and then the result stage; one request per
//   cycle sustained while i_out_ready stays high. Read, find and count
//   rotate the whole ring of DEPTH cells past the head cell, one entry per
//   cycle, taking no request meanwhile; the next request can be taken on the
//   edge that presents the result.
//   A result stage plus a pending stage let one further request be taken
//   while a result stalls; beyond that o_in_ready drops until i_out_ready.
//   Reset empties the stack (fill 0) and drops queued results; the entries
//   themselves are not cleared and are never read before being pushed.
// ---------------------------------------------------------------------------
module searchable_lifo_stack_top import slc_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [IDX_W-1:0]   i_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [DOUT_W-1:0]  o_data_out,
    output logic               o_found,
    output logic [POS_W-1:0]   o_position,
    output logic [CNT_W-1:0]   o_match_count,
    output logic [FILL_W-1:0]  o_fill,
    output logic [STAT_W-1:0]  o_status
);

    // Only the low DATA_WIDTH bits of a request value take part
    logic [DATA_WIDTH-1:0] w_value;
    logic [DATA_WIDTH-1:0] w_cell [DEPTH];
    t_cell_op              w_op;
    t_result               w_res;

    assign w_value = DATA_WIDTH'(i_value);

    // Sequencer: owns occupancy, drives every cell with one shared op,
    // watches the head cell during scans and holds the result stages
    slc_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_req_type  (i_req_type),
        .i_value     (w_value),
        .i_index     (i_index),
        .i_head      (w_cell[0]),
        .o_op        (w_op),
        .o_res_valid (o_out_valid),
        .i_res_ready (i_out_ready),
        .o_res       (w_res)
    );

    // Ring of cells. Cell 0 holds the top of the stack; bottom index k sits
    // in cell fill-1-k. Push moves every entry one cell away from the head
    // and loads the new value into cell 0; pop and scan steps move every
    // entry one cell towards the head, the head wrapping round to the last
    // cell, so DEPTH scan steps leave the ring exactly as it was.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        slc_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_from_prev ((g == 0) ? w_value : w_cell[(g == 0) ? 0 : g - 1]),
            .i_from_next (w_cell[(g + 1) % DEPTH]),
            .o_data      (w_cell[g])
        );
    end

    // Unpack the result record onto the output ports
    assign o_data_out    = w_res.data_out;
    assign o_found       = w_res.found;
    assign o_position    = w_res.position;
    assign o_match_count = w_res.match_count;
    assign o_fill        = w_res.fill;
    assign o_status      = w_res.status;

endmodule

// ===== src/slc_checker.sv =====
// ---------------------------------------------------------------------------
// slc_checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slc_checker import slc_pkg::*; #(
    parameter int DEPTH = 64
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [DOUT_W-1:0]  o_data_out,
    input logic               o_found,
    input logic [CNT_W-1:0]   o_match_count,
    input logic [FILL_W-1:0]  o_fill,
    input logic [STAT_W-1:0]  o_status
);

    // Hold the data, fill and status of a stalled result unchanged
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_data_out) && $stable(o_fill) && $stable(o_status), "stalled result changed")

    `ASSERT_IMPLIES(a_fill_bound, i_clk, i_rst_n, o_out_valid, (DEPTH > 127) || (o_fill <= DEPTH), "fill beyond depth")

    `ASSERT_IMPLIES(a_under_empty, i_clk, i_rst_n, o_out_valid && o_status == STAT_UNDER, o_fill == '0 && o_data_out == '0, "underflow with non-empty stack")

    `ASSERT_IMPLIES(a_over_full, i_clk, i_rst_n, o_out_valid && o_status == STAT_OVER, o_fill == FILL_W'(DEPTH), "overflow while not full")

    `ASSERT_IMPLIES(a_found_excl, i_clk, i_rst_n, o_out_valid && o_found, o_status == STAT_OK && o_match_count == '0 && o_data_out == '0, "found flag with other result fields")

endmodule

bind searchable_lifo_stack_top slc_checker #(.DEPTH(DEPTH)) u_slc_checker (.*);
